>>> rtl/poc_pkg.sv
// ----------------------------------------------------------------------------
// poc_pkg: shared definitions for the palette overlay pixel converter
// Widths, reset values, command and register codes, the scan flag bundle
// and the RGB888 to RGB565 packing function.
// ----------------------------------------------------------------------------
package poc_pkg;

   // Default sizes handed to the top level parameters.
   localparam int PALETTE_DEPTH_DEF = 256;
   localparam int MAX_WIDTH_DEF     = 320;
   localparam int MAX_HEIGHT_DEF    = 240;

   // Field and register widths.
   localparam int INDEX_W = 8;
   localparam int COLOR_W = 24;
   localparam int RGB_W   = 16;
   localparam int COL_W   = 9;
   localparam int LINE_W  = 8;
   localparam int FRAME_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   // Command codes carried by an input item.
   localparam logic CMD_PIXEL         = 1'b0;
   localparam logic CMD_PALETTE_WRITE = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_LINE_WIDTH       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OVERLAY_BASE     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_INDEX_LIMIT = 2'd3;

   // Register reset values.
   localparam logic [COL_W-1:0]   LINE_WIDTH_RST       = 9'd320;
   localparam logic [LINE_W-1:0]  FRAME_HEIGHT_RST     = 8'd240;
   localparam logic [INDEX_W-1:0] OVERLAY_BASE_RST     = 8'd220;
   localparam logic [COL_W-1:0]   BASE_INDEX_LIMIT_RST = 9'd240;

   // Overlay indices below this value are visible.
   localparam logic [INDEX_W-1:0] OVERLAY_VISIBLE_BELOW = 8'h10;

   // Masks that keep the top 5 and 6 bits of a color channel.
   localparam logic [7:0] MASK_5BIT = 8'b11111000;
   localparam logic [7:0] MASK_6BIT = 8'b11111100;

   // Position flags of one pixel item.
   typedef struct packed {
      logic                last_in_line;
      logic                last_in_frame;
      logic [FRAME_W-1:0]  frame_number;
   } scan_flags_type;

   // Keep the top 5/6/5 bits of red, green and blue.
   function automatic logic [RGB_W-1:0] pack_rgb565(input logic [COLOR_W-1:0] rgb);
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      red   = rgb[23:16] & MASK_5BIT;
      green = rgb[15:8] & MASK_6BIT;
      blue  = rgb[7:0] & MASK_5BIT;
      return {red[7:3], green[7:2], blue[7:3]};
   endfunction

endpackage

>>> rtl/poc_palette_ram.sv
// ----------------------------------------------------------------------------
// poc_palette_ram: palette storage
// Single write port and single read port, read data registered and held
// until the next read.
// ----------------------------------------------------------------------------
module poc_palette_ram #(
   parameter int PALETTE_DEPTH = poc_pkg::PALETTE_DEPTH_DEF,
   parameter int AW            = $clog2(PALETTE_DEPTH)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [poc_pkg::RGB_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [poc_pkg::RGB_W-1:0] rd_data
);

   logic [poc_pkg::RGB_W-1:0] mem_ff [PALETTE_DEPTH];
   logic [poc_pkg::RGB_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data stays until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/poc_entry_select.sv
// ----------------------------------------------------------------------------
// poc_entry_select: palette entry selection
// Picks the overlay or the base index, applies the base index limit and
// folds the entry number into the palette depth.
// ----------------------------------------------------------------------------
module poc_entry_select #(
   parameter int PALETTE_DEPTH = poc_pkg::PALETTE_DEPTH_DEF,
   parameter int AW            = $clog2(PALETTE_DEPTH)
) (
   input  logic [poc_pkg::INDEX_W-1:0] base_pixel,
   input  logic [poc_pkg::INDEX_W-1:0] overlay_pixel,
   input  logic                        overlay_on,
   input  logic [poc_pkg::INDEX_W-1:0] overlay_base,
   input  logic [poc_pkg::COL_W-1:0]   base_index_limit,
   output logic [AW-1:0]               entry
);

   // Room for the palette depth shifted by the largest reduction step.
   localparam int RED_STEPS = 5;
   localparam int RED_W     = AW + RED_STEPS + 1;

   logic                        overlay_hit;
   logic [poc_pkg::COL_W-1:0]   raw_entry;
   logic [RED_W-1:0]            rem;
   logic [RED_W-1:0]            step_val;

   assign overlay_hit = overlay_on && (overlay_pixel < poc_pkg::OVERLAY_VISIBLE_BELOW);

   // Entry number before folding, at most nine bits.
   always_comb begin
      if (overlay_hit) begin
         raw_entry = {1'b0, overlay_pixel} + {1'b0, overlay_base};
      end else if ({1'b0, base_pixel} < base_index_limit) begin
         raw_entry = {1'b0, base_pixel};
      end else begin
         raw_entry = '0;
      end
   end

   // Remainder by the palette depth: restoring steps over a narrow value.
   always_comb begin
      rem = RED_W'(raw_entry);
      for (int k = RED_STEPS - 1; k >= 0; k--) begin
         step_val = RED_W'(PALETTE_DEPTH) << k;
         if (rem >= step_val) begin
            rem = rem - step_val;
         end
      end
   end

   assign entry = rem[AW-1:0];

endmodule

>>> rtl/poc_scan_counter.sv
// ----------------------------------------------------------------------------
// poc_scan_counter: column, line and frame counters
// Flags the last pixel of a line and of a frame and counts frames.
// ----------------------------------------------------------------------------
module poc_scan_counter #(
   parameter int MAX_WIDTH  = poc_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = poc_pkg::MAX_HEIGHT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [poc_pkg::COL_W-1:0]    line_width,
   input  logic [poc_pkg::LINE_W-1:0]   frame_height,
   output poc_pkg::scan_flags_type      flags
);

   localparam int WCMP_W = ($clog2(MAX_WIDTH + 1) > poc_pkg::COL_W) ?
                           $clog2(MAX_WIDTH + 1) : poc_pkg::COL_W;
   localparam int HCMP_W = ($clog2(MAX_HEIGHT + 1) > poc_pkg::LINE_W) ?
                           $clog2(MAX_HEIGHT + 1) : poc_pkg::LINE_W;

   logic [poc_pkg::COL_W-1:0]   col_ff, col_in;
   logic [poc_pkg::LINE_W-1:0]  line_ff, line_in;
   logic [poc_pkg::FRAME_W-1:0] frame_ff, frame_in;
   logic [poc_pkg::COL_W-1:0]   width_eff;
   logic [poc_pkg::LINE_W-1:0]  height_eff;
   logic                        eol;
   logic                        eof;

   // Saturate the line width to one through MAX_WIDTH.
   always_comb begin
      if (line_width == '0) begin
         width_eff = poc_pkg::COL_W'(1);
      end else if (WCMP_W'(line_width) > WCMP_W'(MAX_WIDTH)) begin
         width_eff = poc_pkg::COL_W'(MAX_WIDTH);
      end else begin
         width_eff = line_width;
      end
   end

   // Saturate the frame height to one through MAX_HEIGHT.
   always_comb begin
      if (frame_height == '0) begin
         height_eff = poc_pkg::LINE_W'(1);
      end else if (HCMP_W'(frame_height) > HCMP_W'(MAX_HEIGHT)) begin
         height_eff = poc_pkg::LINE_W'(MAX_HEIGHT);
      end else begin
         height_eff = frame_height;
      end
   end

   // A counter at or past the end closes its line or frame.
   assign eol = ({1'b0, col_ff} + 10'd1) >= {1'b0, width_eff};
   assign eof = eol && (({1'b0, line_ff} + 9'd1) >= {1'b0, height_eff});

   assign flags.last_in_line  = eol;
   assign flags.last_in_frame = eof;
   assign flags.frame_number  = frame_ff;

   // Counter updates for an accepted pixel item.
   always_comb begin
      col_in   = col_ff;
      line_in  = line_ff;
      frame_in = frame_ff;
      if (advance) begin
         if (eol) begin
            col_in = '0;
            if (eof) begin
               line_in  = '0;
               frame_in = frame_ff + 1'b1;
            end else begin
               line_in = line_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         line_ff  <= '0;
         frame_ff <= '0;
      end else begin
         col_ff   <= col_in;
         line_ff  <= line_in;
         frame_ff <= frame_in;
      end
   end

endmodule

>>> rtl/palette_overlay_pixel_converter_unit.sv
// ----------------------------------------------------------------------------
// palette_overlay_pixel_converter_unit: indexed pixel to RGB565 converter
// Palette lookup with overlay, line and frame marking and a frame count.
// ----------------------------------------------------------------------------
// The block takes one item per clock and keeps taking items back to back
// while req_stall is low. A pixel item reads the palette in the cycle it is
// accepted; the entry lands in the palette memory's read register while the
// pixel waits in stage one, then moves with its flags into the output
// register that drives the rsp_ port. A palette-write item stores its packed
// color at once and gives no result; a pixel item right behind it already
// sees the new entry. The input is stalled only while a converted pixel is
// waiting behind a stalled result. Palette entries hold no defined value until written.
// ----------------------------------------------------------------------------
module palette_overlay_pixel_converter_unit #(
   parameter int PALETTE_DEPTH = poc_pkg::PALETTE_DEPTH_DEF,
   parameter int MAX_WIDTH     = poc_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT    = poc_pkg::MAX_HEIGHT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Configuration writes.
   input  logic                              csr_write_en,
   input  logic [poc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [poc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // Input items.
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_cmd,
   input  logic [poc_pkg::INDEX_W-1:0]       req_palette_index,
   input  logic [poc_pkg::COLOR_W-1:0]       req_color_rgb888,
   input  logic [poc_pkg::INDEX_W-1:0]       req_base_pixel,
   input  logic [poc_pkg::INDEX_W-1:0]       req_overlay_pixel,
   input  logic                              req_overlay_on,
   // Result items.
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [poc_pkg::RGB_W-1:0]         rsp_rgb565,
   output logic                              rsp_last_in_line,
   output logic                              rsp_last_in_frame,
   output logic [poc_pkg::FRAME_W-1:0]       rsp_frame_number
);

   localparam int AW    = $clog2(PALETTE_DEPTH);
   localparam int CMP_W = (AW + 1 > poc_pkg::INDEX_W) ? AW + 1 : poc_pkg::INDEX_W;

   // Configuration registers.
   logic [poc_pkg::COL_W-1:0]   line_width_ff;
   logic [poc_pkg::LINE_W-1:0]  frame_height_ff;
   logic [poc_pkg::INDEX_W-1:0] overlay_base_ff;
   logic [poc_pkg::COL_W-1:0]   base_limit_ff;

   logic                        accept;
   logic                        pix_acc;
   logic                        wr_acc;
   logic                        out_free;
   logic                        s1_adv;
   logic [AW-1:0]               entry;
   logic [poc_pkg::RGB_W-1:0]   rd_data;
   poc_pkg::scan_flags_type     flags;

   // Stage one: pixel whose palette read is in flight or held.
   logic                        s1_valid_ff, s1_valid_in;
   poc_pkg::scan_flags_type     s1_flags_ff;

   // Output register.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [poc_pkg::RGB_W-1:0]   rsp_rgb_ff;
   poc_pkg::scan_flags_type     rsp_flags_ff;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= poc_pkg::LINE_WIDTH_RST;
         frame_height_ff <= poc_pkg::FRAME_HEIGHT_RST;
         overlay_base_ff <= poc_pkg::OVERLAY_BASE_RST;
         base_limit_ff   <= poc_pkg::BASE_INDEX_LIMIT_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            poc_pkg::REG_LINE_WIDTH: begin
               line_width_ff <= csr_wdata;
            end
            poc_pkg::REG_FRAME_HEIGHT: begin
               frame_height_ff <= csr_wdata[poc_pkg::LINE_W-1:0];
            end
            poc_pkg::REG_OVERLAY_BASE: begin
               overlay_base_ff <= csr_wdata[poc_pkg::INDEX_W-1:0];
            end
            poc_pkg::REG_BASE_INDEX_LIMIT: begin
               base_limit_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Handshake: stage one may move on when the output register is free.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign pix_acc   = accept && (req_cmd == poc_pkg::CMD_PIXEL);
   // Writes past the end of the palette are dropped.
   assign wr_acc    = accept && (req_cmd == poc_pkg::CMD_PALETTE_WRITE) &&
                      (CMP_W'(req_palette_index) < CMP_W'(PALETTE_DEPTH));

   poc_entry_select #(
      .PALETTE_DEPTH (PALETTE_DEPTH),
      .AW            (AW)
   ) u_entry_select (
      .base_pixel       (req_base_pixel),
      .overlay_pixel    (req_overlay_pixel),
      .overlay_on       (req_overlay_on),
      .overlay_base     (overlay_base_ff),
      .base_index_limit (base_limit_ff),
      .entry            (entry)
   );

   poc_palette_ram #(
      .PALETTE_DEPTH (PALETTE_DEPTH),
      .AW            (AW)
   ) u_palette_ram (
      .clock   (clock),
      .wr_en   (wr_acc),
      .wr_addr (AW'(req_palette_index)),
      .wr_data (poc_pkg::pack_rgb565(req_color_rgb888)),
      .rd_en   (pix_acc),
      .rd_addr (entry),
      .rd_data (rd_data)
   );

   poc_scan_counter #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_scan_counter (
      .clock        (clock),
      .reset        (reset),
      .advance      (pix_acc),
      .line_width   (line_width_ff),
      .frame_height (frame_height_ff),
      .flags        (flags)
   );

   // Valid bits of stage one and the output register.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (pix_acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload of stage one and the output register.
   always_ff @(posedge clock) begin
      if (pix_acc) begin
         s1_flags_ff <= flags;
      end
      if (s1_adv) begin
         rsp_rgb_ff   <= rd_data;
         rsp_flags_ff <= s1_flags_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_rgb565        = rsp_rgb_ff;
   assign rsp_last_in_line  = rsp_flags_ff.last_in_line;
   assign rsp_last_in_frame = rsp_flags_ff.last_in_frame;
   assign rsp_frame_number  = rsp_flags_ff.frame_number;

endmodule
